// ===== sv/mtru_pkg.sv =====
// Shared types, constants and helper functions for the Modbus TCP response unpacker.
`timescale 1ns / 1ps

package mtru_pkg;

   // Field widths of the byte channel and the result channel.
   localparam int RX_BYTE_W     = 8;
   localparam int COIL_COUNT_W  = 11;
   localparam int INDEX_W       = 16;
   localparam int VALUE_W       = 16;
   localparam int KIND_W        = 2;
   localparam int SEL_W         = 3;

   // Modbus function codes that the parser distinguishes.
   localparam logic [7:0] FC_READ_COILS    = 8'd1;
   localparam logic [7:0] FC_READ_INPUTS   = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
   localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
   localparam logic [7:0] FC_WRITE_REG     = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

   // Frame kind reported on every result.
   typedef enum logic [KIND_W-1:0] {
      KIND_BIT     = 2'd0,
      KIND_REG     = 2'd1,
      KIND_ACK     = 2'd2,
      KIND_UNKNOWN = 2'd3
   } kind_type;

   // Group from one received byte, drained one result per cycle while ready is high.
   typedef struct packed {
      logic                 bit_mode;
      logic                 has_write;
      logic                 frame_done;
      kind_type             kind;
      logic [SEL_W-1:0]     last_sel;
      logic [INDEX_W-1:0]   index;
      logic [VALUE_W-1:0]   word;
   } desc_type;

   // Classifies a function code into a frame kind.
   function automatic kind_type kind_of(input logic [7:0] fc);
      kind_type k;
      priority if (fc == FC_READ_COILS || fc == FC_READ_INPUTS) begin
         k = KIND_BIT;
      end else if (fc == FC_READ_HOLDING) begin
         k = KIND_REG;
      end else if (fc == FC_WRITE_COIL || fc == FC_WRITE_COILS ||
                   fc == FC_WRITE_REG || fc == FC_WRITE_REGS) begin
         k = KIND_ACK;
      end else begin
         k = KIND_UNKNOWN;
      end
      return k;
   endfunction

endpackage

// ===== sv/mtru_if.sv =====
// Valid/ready channel interfaces for received bytes and for table-write results.
`timescale 1ns / 1ps

interface mtru_req_if;
   import mtru_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [RX_BYTE_W-1:0]    rx_byte;
   logic [COIL_COUNT_W-1:0] coil_count;

   modport source (output valid, output rx_byte, output coil_count, input ready);
   modport sink   (input valid, input rx_byte, input coil_count, output ready);
endinterface

interface mtru_rsp_if;
   import mtru_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       write_valid;
   logic [INDEX_W-1:0]         write_index;
   logic signed [VALUE_W-1:0]  write_value;
   logic                       frame_done;
   logic [KIND_W-1:0]          frame_kind;
   logic                       last;

   modport source (output valid, output write_valid, output write_index,
                   output write_value, output frame_done, output frame_kind,
                   output last, input ready);
   modport sink   (input valid, input write_valid, input write_index,
                   input write_value, input frame_done, input frame_kind,
                   input last, output ready);
endinterface

// ===== sv/mtru_parser.sv =====
// Frame parser: header, unit id, function code and data bytes to result groups.
`timescale 1ns / 1ps

module mtru_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [mtru_pkg::RX_BYTE_W-1:0]    rx_byte,
   input  logic [mtru_pkg::COIL_COUNT_W-1:0] coil_count,
   output logic                              desc_load,
   output mtru_pkg::desc_type                desc
);
   import mtru_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_UNIT   = 3'd1,
      PH_FUNC   = 3'd2,
      PH_COUNT  = 3'd3,
      PH_DATA   = 3'd4,
      PH_SKIP   = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [15:0] base_ff, base_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  fc_ff, fc_in;
   logic [7:0]  dbytes_ff, dbytes_in;
   logic [7:0]  dpos_ff, dpos_in;
   logic [7:0]  hold_ff, hold_in;

   logic [15:0]             left_dec;
   logic [15:0]             left_hdr;
   logic [7:0]              reg_limit;
   logic [COIL_COUNT_W-1:0] pos_bits;
   logic [COIL_COUNT_W-1:0] bits_left;
   logic [3:0]              bit_count;
   logic [3:0]              n_writes;
   logic                    frame_end;
   kind_type                end_kind;
   kind_type                write_kind;
   logic                    bit_mode;
   logic [15:0]             write_idx;
   logic [15:0]             write_word;

   // Bits still expected by the pending bit read from this data byte onward.
   assign pos_bits  = {dpos_ff, 3'b000};
   assign bits_left = coil_count - pos_bits;
   assign bit_count = (coil_count <= pos_bits) ? 4'd0 :
                      (bits_left >= COIL_COUNT_W'(8)) ? 4'd8 : bits_left[3:0];
   assign left_dec  = left_ff - 16'd1;
   assign left_hdr  = {left_ff[15:8], rx_byte};
   assign reg_limit = {dbytes_ff[7:1], 1'b0};

   // Next parser state and the result group caused by the current byte.
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      base_in    = base_ff;
      left_in    = left_ff;
      fc_in      = fc_ff;
      dbytes_in  = dbytes_ff;
      dpos_in    = dpos_ff;
      hold_in    = hold_ff;
      n_writes   = 4'd0;
      frame_end  = 1'b0;
      end_kind   = KIND_UNKNOWN;
      write_kind = KIND_BIT;
      bit_mode   = 1'b0;
      write_idx  = '0;
      write_word = '0;

      if (phase_ff == PH_HEADER) begin
         unique case (hdr_cnt_ff)
            3'd0:    base_in = {rx_byte, 8'h00};
            3'd1:    base_in = {base_ff[15:8], rx_byte};
            3'd4:    left_in = {rx_byte, 8'h00};
            3'd5:    left_in = left_hdr;
            default: ;
         endcase
         if (hdr_cnt_ff == 3'd5) begin
            hdr_cnt_in = 3'd0;
            if (left_hdr == 16'd0) begin
               frame_end = 1'b1;
            end else begin
               phase_in = PH_UNIT;
            end
         end else begin
            hdr_cnt_in = hdr_cnt_ff + 3'd1;
         end
      end else begin
         left_in = left_dec;
         unique case (phase_ff)
            PH_UNIT: begin
               phase_in = PH_FUNC;
            end
            PH_FUNC: begin
               fc_in    = rx_byte;
               phase_in = (kind_of(rx_byte) == KIND_BIT || kind_of(rx_byte) == KIND_REG) ?
                          PH_COUNT : PH_SKIP;
            end
            PH_COUNT: begin
               dbytes_in = rx_byte;
               dpos_in   = 8'd0;
               phase_in  = PH_DATA;
            end
            PH_DATA: begin
               if (kind_of(fc_ff) == KIND_BIT) begin
                  if (dpos_ff < dbytes_ff) begin
                     bit_mode   = 1'b1;
                     write_kind = KIND_BIT;
                     n_writes   = bit_count;
                     write_idx  = base_ff + {5'b00000, pos_bits};
                     write_word = {8'h00, rx_byte};
                     dpos_in    = dpos_ff + 8'd1;
                  end
               end else begin
                  if (dpos_ff < reg_limit) begin
                     if (dpos_ff[0] == 1'b0) begin
                        hold_in = rx_byte;
                     end else begin
                        write_kind = KIND_REG;
                        n_writes   = 4'd1;
                        write_idx  = base_ff + {9'b0, dpos_ff[7:1]};
                        write_word = {hold_ff, rx_byte};
                     end
                     dpos_in = dpos_ff + 8'd1;
                  end
               end
            end
            default: ;
         endcase
         if (left_dec == 16'd0) begin
            frame_end  = 1'b1;
            end_kind   = (phase_ff == PH_UNIT) ? KIND_UNKNOWN : kind_of(fc_in);
            phase_in   = PH_HEADER;
            hdr_cnt_in = 3'd0;
         end
      end
   end

   // Pack the result group for the expander.
   always_comb begin
      desc.bit_mode   = bit_mode;
      desc.has_write  = (n_writes != 4'd0);
      desc.frame_done = frame_end;
      desc.kind       = (n_writes != 4'd0) ? write_kind : end_kind;
      desc.last_sel   = (n_writes != 4'd0) ? SEL_W'(n_writes - 4'd1) : '0;
      desc.index      = write_idx;
      desc.word       = write_word;
   end

   assign desc_load = accept && ((n_writes != 4'd0) || frame_end);

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= 3'd0;
         base_ff    <= 16'd0;
         left_ff    <= 16'd0;
         fc_ff      <= 8'd0;
         dbytes_ff  <= 8'd0;
         dpos_ff    <= 8'd0;
         hold_ff    <= 8'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         base_ff    <= base_in;
         left_ff    <= left_in;
         fc_ff      <= fc_in;
         dbytes_ff  <= dbytes_in;
         dpos_ff    <= dpos_in;
         hold_ff    <= hold_in;
      end
   end

endmodule

// ===== sv/mtru_expander.sv =====
// Result register draining a result group, one write per cycle when ready.
`timescale 1ns / 1ps

module mtru_expander (
   input  logic               clock,
   input  logic               reset,
   input  logic               desc_load,
   input  mtru_pkg::desc_type desc,
   output logic               take_ready,
   mtru_rsp_if.source         rsp_ch
);
   import mtru_pkg::*;

   logic             valid_ff, valid_in;
   logic [SEL_W-1:0] sel_ff, sel_in;
   desc_type         desc_ff, desc_in;
   logic             is_last;
   logic             rsp_take;

   assign is_last    = (sel_ff == desc_ff.last_sel);
   assign rsp_take   = valid_ff && rsp_ch.ready;
   assign take_ready = !valid_ff || (rsp_ch.ready && is_last);

   // Load a new group, step to the next result, or empty out.
   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      desc_in  = desc_ff;
      if (desc_load) begin
         valid_in = 1'b1;
         sel_in   = '0;
         desc_in  = desc;
      end else if (rsp_take) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            sel_in = sel_ff + SEL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
      desc_ff <= desc_in;
   end

   // Result fields for the current position in the group.
   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.write_valid = desc_ff.has_write;
   assign rsp_ch.write_index = desc_ff.has_write ?
                               desc_ff.index + {{(INDEX_W-SEL_W){1'b0}}, sel_ff} : '0;
   assign rsp_ch.write_value = !desc_ff.has_write ? '0 :
                               desc_ff.bit_mode ? $signed({VALUE_W{desc_ff.word[sel_ff]}}) :
                               $signed(desc_ff.word);
   assign rsp_ch.frame_done  = is_last && desc_ff.frame_done;
   assign rsp_ch.frame_kind  = desc_ff.kind;
   assign rsp_ch.last        = is_last;

endmodule

// ===== sv/modbus_tcp_response_unpacker.sv =====
// Top level of the Modbus TCP response unpacker.
`timescale 1ns / 1ps

// Accepts a Modbus TCP response stream one byte per transaction and turns it into
// table writes. The header's transaction id is the table base index and its length
// field decides where the frame ends. Bit-read replies (functions 1 and 2) give one
// write of -1 or 0 per data bit up to coil_count, register replies (function 3) one
// write per big-endian word; write acknowledges and unknown functions give only the
// frame-end result. A byte is taken while the result register is empty or hands out
// its last result; a data byte of a bit read yields up to eight results, which leave
// the result register one per cycle while the receiver is ready. The next byte is
// accepted in the same cycle as the last result of the previous one.
module modbus_tcp_response_unpacker (
   input  logic       clock,
   input  logic       reset,
   mtru_req_if.sink   req_ch,
   mtru_rsp_if.source rsp_ch
);
   import mtru_pkg::*;

   logic     desc_load;
   desc_type desc;
   logic     take_ready;
   logic     accept;

   assign req_ch.ready = take_ready;
   assign accept       = req_ch.valid && take_ready;

   mtru_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_ch.rx_byte),
      .coil_count (req_ch.coil_count),
      .desc_load  (desc_load),
      .desc       (desc)
   );

   mtru_expander u_expander (
      .clock      (clock),
      .reset      (reset),
      .desc_load  (desc_load),
      .desc       (desc),
      .take_ready (take_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the Modbus TCP response unpacker with a write scoreboard.
`timescale 1ns / 1ps

module tb;
   import mtru_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned MAX_REPORTS = 40;
   localparam int unsigned ITEM_COUNT = 250;

   // Parser position within a response frame.
   typedef enum logic [2:0] {
      SCAN_HEADER,
      SCAN_UNIT,
      SCAN_FUNC,
      SCAN_COUNT,
      SCAN_DATA,
      SCAN_SKIP
   } scan_phase_type;

   // One table-write result as it appears on the result channel.
   typedef struct packed {
      logic               write_valid;
      logic [INDEX_W-1:0] write_index;
      logic [VALUE_W-1:0] write_value;
      logic               frame_done;
      kind_type           frame_kind;
      logic               last;
   } write_result_type;

   // Tracks the frame parser state and holds the table writes still owed by the block.
   class table_write_scoreboard;
      write_result_type pending_writes[$];
      int unsigned      error_count;
      int unsigned      result_count;
      scan_phase_type   phase;
      logic [2:0]       hdr_count;
      logic [15:0]      base;
      logic [15:0]      remaining;
      logic [7:0]       func;
      logic [7:0]       byte_total;
      logic [7:0]       byte_pos;
      logic [7:0]       high_hold;

      function new();
         phase = SCAN_HEADER;
         hdr_count = '0;
         base = '0;
         remaining = '0;
         func = '0;
         byte_total = '0;
         byte_pos = '0;
         high_hold = '0;
         error_count = 0;
         result_count = 0;
      endfunction

      function int unsigned pending();
         return pending_writes.size();
      endfunction

      task report_mismatch(input string what);
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("MISMATCH at %0t: %s", $time, what);
         end
      endtask

      function kind_type frame_class(input logic [7:0] fc);
         if (fc == FC_READ_COILS || fc == FC_READ_INPUTS) return KIND_BIT;
         if (fc == FC_READ_HOLDING) return KIND_REG;
         if (fc == FC_WRITE_COIL || fc == FC_WRITE_COILS ||
             fc == FC_WRITE_REG || fc == FC_WRITE_REGS) return KIND_ACK;
         return KIND_UNKNOWN;
      endfunction

      function write_result_type make_result(input logic valid, input logic [15:0] idx,
                                             input logic [15:0] val, input logic done,
                                             input kind_type kind);
         write_result_type r;
         r.write_valid = valid;
         r.write_index = idx;
         r.write_value = val;
         r.frame_done = done;
         r.frame_kind = kind;
         r.last = 1'b0;
         return r;
      endfunction

      // Advances the parser by one accepted byte and queues the writes it causes.
      function void note_byte(input logic [7:0] b, input logic [10:0] coils);
         write_result_type group[$];
         scan_phase_type   entry;
         kind_type         fk;
         int unsigned      ix;
         int               j;
         if (phase == SCAN_HEADER) begin
            case (hdr_count)
               3'd0: base = {b, 8'h00};
               3'd1: base[7:0] = b;
               3'd4: remaining = {b, 8'h00};
               3'd5: remaining[7:0] = b;
               default: ;
            endcase
            if (hdr_count == 3'd5) begin
               hdr_count = '0;
               // An empty body ends the frame right on the header.
               if (remaining == 16'd0) begin
                  group.push_back(make_result(1'b0, '0, '0, 1'b1, KIND_UNKNOWN));
               end else begin
                  phase = SCAN_UNIT;
               end
            end else begin
               hdr_count++;
            end
         end else begin
            entry = phase;
            remaining = remaining - 16'd1;
            case (entry)
               SCAN_UNIT: phase = SCAN_FUNC;
               SCAN_FUNC: begin
                  func = b;
                  fk = frame_class(b);
                  phase = (fk == KIND_BIT || fk == KIND_REG) ? SCAN_COUNT : SCAN_SKIP;
               end
               SCAN_COUNT: begin
                  byte_total = b;
                  byte_pos = '0;
                  phase = SCAN_DATA;
               end
               SCAN_DATA: begin
                  if (frame_class(func) == KIND_BIT) begin
                     // Each bit becomes -1 or 0, up to the expected coil count.
                     if (byte_pos < byte_total) begin
                        for (j = 0; j < 8; j++) begin
                           ix = int'(byte_pos) * 8 + j;
                           if (ix < coils) begin
                              group.push_back(make_result(1'b1, base + 16'(ix),
                                                          b[j] ? 16'hFFFF : 16'h0000,
                                                          1'b0, KIND_BIT));
                           end
                        end
                        byte_pos++;
                     end
                  end else begin
                     // Big-endian words; a trailing odd byte is dropped.
                     if (byte_pos < {byte_total[7:1], 1'b0}) begin
                        if (!byte_pos[0]) begin
                           high_hold = b;
                        end else begin
                           group.push_back(make_result(1'b1, base + 16'(byte_pos[7:1]),
                                                       {high_hold, b}, 1'b0, KIND_REG));
                        end
                        byte_pos++;
                     end
                  end
               end
               default: ;
            endcase
            // The length field alone decides where the frame ends.
            if (remaining == 16'd0) begin
               if (group.size() > 0) begin
                  group[group.size()-1].frame_done = 1'b1;
               end else begin
                  group.push_back(make_result(1'b0, '0, '0, 1'b1,
                                  (entry == SCAN_UNIT) ? KIND_UNKNOWN : frame_class(func)));
               end
               phase = SCAN_HEADER;
               hdr_count = '0;
            end
         end
         if (group.size() > 0) begin
            group[group.size()-1].last = 1'b1;
         end
         foreach (group[i]) pending_writes.push_back(group[i]);
      endfunction

      task check_field(input string name, input logic [15:0] got, input logic [15:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                      result_count, name, got, want));
         end
      endtask

      // Compares one accepted result with the oldest expected write.
      task check_result(input logic valid, input logic [15:0] idx, input logic [15:0] val,
                        input logic done, input logic [1:0] kind, input logic last);
         write_result_type want;
         if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      result_count));
         end else begin
            want = pending_writes.pop_front();
            check_field("write_valid", 16'(valid), 16'(want.write_valid));
            check_field("write_index", idx, want.write_index);
            check_field("write_value", val, want.write_value);
            check_field("frame_done", 16'(done), 16'(want.frame_done));
            check_field("frame_kind", 16'(kind), 16'(want.frame_kind));
            check_field("last", 16'(last), 16'(want.last));
         end
         result_count++;
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   int unsigned cycles = 0;
   int unsigned sent_bytes = 0;
   int          burst_left = 0;

   table_write_scoreboard sb;

   mtru_req_if req_ch ();
   mtru_rsp_if rsp_ch ();

   modbus_tcp_response_unpacker i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #5 clock = ~clock;

   // Cycle counter and run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("modbus_tcp_response_unpacker regression: fail");
         $finish;
      end
   end

   // Receiver stall pattern that steps through four characters in turn.
   always @(posedge clock) begin
      case ((cycles / 97) % 4)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         2: rsp_ch.ready <= ((cycles % 4) != 3);
         default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // Both channels are observed at the same edge; a byte is noted before results are checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_byte(req_ch.rx_byte, req_ch.coil_count);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_ch.write_valid, rsp_ch.write_index, rsp_ch.write_value,
                            rsp_ch.frame_done, rsp_ch.frame_kind, rsp_ch.last);
         end
      end
   end

   // Presents one byte after any idle gap and holds it until the transaction completes.
   task automatic send_byte(input logic [7:0] b, input logic [10:0] coils);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            req_ch.rx_byte <= 8'($urandom);
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      req_ch.coil_count <= coils;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_bytes++;
   endtask

   // Sends a header and exactly length body bytes; the body is cut or padded as needed.
   task automatic send_frame(input logic [15:0] id, input logic [7:0] fc, input int count,
                             input int length, input logic [10:0] coils);
      logic [7:0] body[$];
      int         k;
      send_byte(id[15:8], 11'($urandom_range(0, 2000)));
      send_byte(id[7:0], 11'($urandom_range(0, 2000)));
      send_byte(8'($urandom), 11'($urandom_range(0, 2000)));
      send_byte(8'($urandom), 11'($urandom_range(0, 2000)));
      send_byte(8'(length >> 8), 11'($urandom_range(0, 2000)));
      send_byte(8'(length), 11'($urandom_range(0, 2000)));
      body.push_back(8'($urandom));
      body.push_back(fc);
      body.push_back(8'(count));
      for (k = 0; k < count; k++) body.push_back(8'($urandom));
      while (body.size() < length) body.push_back(8'($urandom));
      for (k = 0; k < length; k++) begin
         send_byte(body[k], (k < 3) ? 11'($urandom_range(0, 2000)) : coils);
      end
   endtask

   // Coil counts: mostly near the reply size, sometimes the extremes.
   function automatic logic [10:0] pick_coils(input int count);
      case ($urandom_range(0, 5))
         0: return 11'd2000;
         1: return 11'd0;
         2: return 11'($urandom_range(0, 2000));
         default: return 11'($urandom_range(0, count * 8 + 4));
      endcase
   endfunction

   function automatic logic [15:0] pick_id();
      return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                         : 16'($urandom);
   endfunction

   // One random frame: mostly well-formed replies, some with a length that disagrees.
   task automatic random_frame();
      int         count;
      int         length;
      logic [7:0] fc;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            fc = $urandom_range(0, 1) ? FC_READ_COILS : FC_READ_INPUTS;
            count = $urandom_range(0, 4);
            send_frame(pick_id(), fc, count, count + 3, pick_coils(count));
         end
         3, 4, 5: begin
            count = $urandom_range(0, 7);
            send_frame(pick_id(), FC_READ_HOLDING, count, count + 3, pick_coils(count));
         end
         6: begin
            case ($urandom_range(0, 3))
               0: fc = FC_WRITE_COIL;
               1: fc = FC_WRITE_REG;
               2: fc = FC_WRITE_COILS;
               default: fc = FC_WRITE_REGS;
            endcase
            send_frame(pick_id(), fc, 0, $urandom_range(2, 8), pick_coils(0));
         end
         7: begin
            send_frame(pick_id(), 8'($urandom), $urandom_range(0, 4),
                       $urandom_range(0, 8), pick_coils(4));
         end
         default: begin
            case ($urandom_range(0, 3))
               0: fc = FC_READ_COILS;
               1: fc = FC_READ_INPUTS;
               2: fc = FC_READ_HOLDING;
               default: fc = 8'($urandom);
            endcase
            count = $urandom_range(0, 6);
            length = $urandom_range(0, count + 6);
            send_frame(pick_id(), fc, count, length, pick_coils(count));
         end
      endcase
   endtask

   initial begin
      int unsigned target;
      sb = new();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= '0;
      req_ch.coil_count <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed frames: empty body, body of only the unit id, a bit read that wraps the index.
      send_frame(16'hFFFF, 8'($urandom), 0, 0, 11'd0);
      send_frame(16'h0000, FC_READ_HOLDING, 0, 1, 11'd0);
      send_frame(16'hFFFC, FC_READ_COILS, 1, 4, 11'd2000);

      // A longer register reply with an odd byte count.
      send_frame(pick_id(), FC_READ_HOLDING, 27, 30, pick_coils(0));

      // Let the block drain completely before the random part.
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      burst_left = 0;

      target = ITEM_COUNT;
      while (sent_bytes < target) random_frame();

      // Wait for every owed write, then give the block time to show anything extra.
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.error_count == 0) begin
         $display("modbus_tcp_response_unpacker regression: pass");
      end else begin
         $display("modbus_tcp_response_unpacker regression: fail");
      end
      $finish;
   end

endmodule
